/* rtl/hpe_pkg.sv */
// Shared types, register codes and the sigmoid entry function for the heatmap peak extractor.
// No dependencies.
package hpe_pkg;

    localparam int unsigned MAX_COLUMNS_DEF     = 256;
    localparam int unsigned MAX_KEYPOINTS_DEF   = 64;
    localparam int unsigned SIGMOID_ENTRIES_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH         = 8;

    localparam logic [15:0] THRESHOLD_RST = 16'd217;
    localparam logic [8:0]  ROWS_RST      = 9'd17;
    localparam logic [8:0]  COLUMNS_RST   = 9'd17;
    localparam logic [6:0]  KEYPOINTS_RST = 7'd17;
    localparam logic [11:0] BLOCK_W_RST   = 12'd16;
    localparam logic [11:0] BLOCK_H_RST   = 12'd16;

    localparam longint unsigned Q31_ONE = 64'd2147483648;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_ROWS      = 3'd1,
        REG_COLUMNS   = 3'd2,
        REG_KEYPOINTS = 3'd3,
        REG_BLOCK_W   = 3'd4,
        REG_BLOCK_H   = 3'd5
    } reg_idx_t;

    // Clamped grid sizes and scale factors, as the datapath sees them
    typedef struct packed {
        logic signed [15:0] thr;
        logic [8:0]         rows;
        logic [8:0]         cols;
        logic [6:0]         planes;
        logic [11:0]        bw;
        logic [11:0]        bh;
    } cfg_t;

    // One queued input: which of its four decision points are peaks and their data
    typedef struct packed {
        logic [3:0]              peak;
        logic [3:0][15:0]        score;
        logic [3:0][15:0]        off_y;
        logic [3:0][15:0]        off_x;
        logic [7:0]              row;
        logic [7:0]              col;
        logic [5:0]              plane;
    } job_t;

    // restoring long division, used only while building constant tables
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], a[k]};
            if (r >= b)
            begin
                r = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] sigmoid_entry(int unsigned i, int unsigned n);
        longint          d;
        longint          ad;
        longint unsigned u;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        d = 2 * longint'(i) + 1 - longint'(n);
        ad = (d < 0) ? -d : d;
        u = udiv64(unsigned'(ad) << 30, longint'(n));
        term = Q31_ONE;
        sum = longint'(Q31_ONE);
        for (int k = 1; k <= 14; k++)
        begin
            term = udiv64((term * u) >> 31, longint'(k));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = (sum < 0) ? 64'd0 : longint'(sum);
        if (e > Q31_ONE)
            e = Q31_ONE;
        for (int k = 0; k < 4; k++)
            e = (e * e + (64'd1 << 30)) >> 31;
        num = (d >= 0) ? Q31_ONE : e;
        den = Q31_ONE + e;
        q = udiv64(num * 64'd65536 + (den >> 1), den);
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage

/* rtl/hpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpe_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/hpe_front.sv */
// Front end: position counters, line buffer, 3x3 window and peak classification.
// Depends on hpe_pkg and hpe_ram.
module hpe_front #(
    parameter int unsigned MAX_COLUMNS = hpe_pkg::MAX_COLUMNS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hpe_pkg::cfg_t            cfg,
    input  logic                     cell_valid,
    output logic                     cell_ready,
    input  logic signed [15:0]       cell_score,
    input  logic signed [15:0]       offset_y,
    input  logic signed [15:0]       offset_x,
    input  logic [$clog2(hpe_pkg::QUEUE_DEPTH+1)-1:0] q_free,
    output logic                     push,
    output hpe_pkg::job_t            push_job
);
    import hpe_pkg::*;

    localparam int unsigned LINE_DEPTH = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int unsigned AW = $clog2(LINE_DEPTH);
    localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);

    // line word: score of row r-1, score of row r-2, offsets of row r-1
    typedef struct packed {
        logic [15:0] s_r1;
        logic [15:0] s_r2;
        logic [31:0] o_r1;
    } line_t;

    logic [7:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;
    logic [5:0] plane_reg, plane_next;
    logic [7:0] r_eff, c_eff;
    logic [5:0] p_eff;
    logic [8:0] c_inc, r_inc;
    logic [6:0] p_inc;
    logic       acc;

    logic        s1_valid_reg;
    logic [15:0] s1_score_reg;
    logic [31:0] s1_off_reg;
    logic [7:0]  s1_row_reg, s1_col_reg;
    logic [5:0]  s1_plane_reg;
    logic [3:0]  s1_flag_reg;
    logic        s1_top_reg, s1_left_reg;

    logic        s2_valid_reg;
    logic [7:0]  s2_row_reg, s2_col_reg;
    logic [5:0]  s2_plane_reg;
    logic [3:0]  s2_flag_reg;
    logic        s2_top_reg, s2_left_reg;

    logic signed [15:0] win_reg [3][3];
    logic [31:0] o1_reg [2];
    logic [31:0] o2_reg [2];

    line_t      line_q;
    line_t      line_d;
    logic [3:0] flag0;
    logic [3:0] peak;

    assign r_eff = ({1'b0, row_reg} >= cfg.rows) ? 8'd0 : row_reg;
    assign c_eff = ({1'b0, col_reg} >= cfg.cols) ? 8'd0 : col_reg;
    assign p_eff = ({1'b0, plane_reg} >= cfg.planes) ? 6'd0 : plane_reg;
    assign c_inc = {1'b0, c_eff} + 9'd1;
    assign r_inc = {1'b0, r_eff} + 9'd1;
    assign p_inc = {1'b0, p_eff} + 7'd1;

    // hold off unless every word in flight is sure of a queue slot
    assign cell_ready = ({{(QW-1){1'b0}}, s1_valid_reg} + {{(QW-1){1'b0}}, s2_valid_reg}) < q_free;
    assign acc = cell_valid && cell_ready;

    always_comb
    begin
        flag0[0] = (r_eff != 8'd0) && (c_eff != 8'd0);
        flag0[1] = (r_eff != 8'd0) && (c_inc == cfg.cols);
        flag0[2] = (r_inc == cfg.rows) && (c_eff != 8'd0);
        flag0[3] = (r_inc == cfg.rows) && (c_inc == cfg.cols);
    end

    always_comb
    begin
        row_next = r_eff;
        col_next = c_eff;
        plane_next = p_eff;
        if (c_inc >= cfg.cols)
        begin
            col_next = 8'd0;
            if (r_inc >= cfg.rows)
            begin
                row_next = 8'd0;
                plane_next = (p_inc >= cfg.planes) ? 6'd0 : p_inc[5:0];
            end
            else
            begin
                row_next = r_inc[7:0];
            end
        end
        else
        begin
            col_next = c_inc[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 8'd0;
            col_reg <= 8'd0;
            plane_reg <= 6'd0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            if (acc)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                plane_reg <= plane_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_score_reg <= cell_score;
            s1_off_reg <= {offset_y, offset_x};
            s1_row_reg <= r_eff;
            s1_col_reg <= c_eff;
            s1_plane_reg <= p_eff;
            s1_flag_reg <= flag0;
            s1_top_reg <= (r_eff >= 8'd2);
            s1_left_reg <= (c_eff >= 8'd2);
        end
        if (s1_valid_reg)
        begin
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg;
            s2_plane_reg <= s1_plane_reg;
            s2_flag_reg <= s1_flag_reg;
            s2_top_reg <= s1_top_reg;
            s2_left_reg <= s1_left_reg;
            // advance the window by one column
            for (int y = 0; y < 3; y++)
            begin
                win_reg[y][0] <= win_reg[y][1];
                win_reg[y][1] <= win_reg[y][2];
            end
            win_reg[0][2] <= line_q.s_r2;
            win_reg[1][2] <= line_q.s_r1;
            win_reg[2][2] <= s1_score_reg;
            o1_reg[0] <= o1_reg[1];
            o1_reg[1] <= line_q.o_r1;
            o2_reg[0] <= o2_reg[1];
            o2_reg[1] <= s1_off_reg;
        end
    end

    assign line_d = '{s_r1: s1_score_reg, s_r2: line_q.s_r1, o_r1: s1_off_reg};

    hpe_ram #(
        .WIDTH ($bits(line_t)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg[AW-1:0]),
        .wdata (line_d),
        .re    (acc),
        .raddr (c_eff[AW-1:0]),
        .rdata (line_q)
    );

    function automatic logic is_peak(input logic [1:0] cy, input logic [1:0] cx,
                                     input logic top_ok, input logic left_ok);
        logic ok;
        logic signed [15:0] ctr;
        ok = 1'b1;
        ctr = win_reg[cy][cx];
        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                if ((y + 1 >= int'(cy)) && (y <= int'(cy) + 1) &&
                    (x + 1 >= int'(cx)) && (x <= int'(cx) + 1) &&
                    ((y != 0) || top_ok) && ((x != 0) || left_ok))
                begin
                    if (win_reg[y][x] > ctr)
                        ok = 1'b0;
                end
            end
        end
        return ok && (ctr >= cfg.thr);
    endfunction

    always_comb
    begin
        peak[0] = s2_flag_reg[0] && is_peak(2'd1, 2'd1, s2_top_reg, s2_left_reg);
        peak[1] = s2_flag_reg[1] && is_peak(2'd1, 2'd2, s2_top_reg, s2_left_reg);
        peak[2] = s2_flag_reg[2] && is_peak(2'd2, 2'd1, s2_top_reg, s2_left_reg);
        peak[3] = s2_flag_reg[3] && is_peak(2'd2, 2'd2, s2_top_reg, s2_left_reg);
    end

    always_comb
    begin
        push_job.peak = peak;
        push_job.score[0] = win_reg[1][1];
        push_job.score[1] = win_reg[1][2];
        push_job.score[2] = win_reg[2][1];
        push_job.score[3] = win_reg[2][2];
        push_job.off_y[0] = o1_reg[0][31:16];
        push_job.off_x[0] = o1_reg[0][15:0];
        push_job.off_y[1] = o1_reg[1][31:16];
        push_job.off_x[1] = o1_reg[1][15:0];
        push_job.off_y[2] = o2_reg[0][31:16];
        push_job.off_x[2] = o2_reg[0][15:0];
        push_job.off_y[3] = o2_reg[1][31:16];
        push_job.off_x[3] = o2_reg[1][15:0];
        push_job.row = s2_row_reg;
        push_job.col = s2_col_reg;
        push_job.plane = s2_plane_reg;
    end

    assign push = s2_valid_reg && (peak != 4'd0);

endmodule

/* rtl/hpe_queue.sv */
// Short job queue between the front end and the back end.
// Depends on hpe_pkg.
module hpe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hpe_pkg::job_t push_job,
    input  logic          pop,
    output hpe_pkg::job_t head,
    output logic          not_empty,
    output logic [$clog2(hpe_pkg::QUEUE_DEPTH+1)-1:0] free
);
    import hpe_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            // depth is a power of two: pointers wrap by themselves
            if (push)
                wr_reg <= wr_reg + PW'(1);
            if (pop)
                rd_reg <= rd_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    assign head = slot_reg[rd_reg];
    assign not_empty = (count_reg != '0);
    assign free = CW'(QUEUE_DEPTH) - count_reg;

endmodule

/* rtl/hpe_back.sv */
// Back end: walks the peaks of each queued job, scales positions, looks up confidence.
// Depends on hpe_pkg.
module hpe_back #(
    parameter int unsigned SIGMOID_ENTRIES = hpe_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hpe_pkg::cfg_t       cfg,
    input  hpe_pkg::job_t       head,
    input  logic                not_empty,
    output logic                pop,
    output logic                peak_valid,
    input  logic                peak_ready,
    output logic [5:0]          keypoint_id,
    output logic [7:0]          peak_row,
    output logic [7:0]          peak_column,
    output logic signed [18:0]  pos_y,
    output logic signed [18:0]  pos_x,
    output logic signed [15:0]  peak_logit,
    output logic [15:0]         confidence,
    output logic                last_of_run
);
    import hpe_pkg::*;

    localparam int unsigned IW = $clog2(SIGMOID_ENTRIES);
    localparam logic [12:0] N13 = 13'(SIGMOID_ENTRIES);

    function automatic logic [SIGMOID_ENTRIES*16-1:0] build_sigmoid();
        logic [SIGMOID_ENTRIES*16-1:0] t;
        t = '0;
        for (int unsigned i = 0; i < SIGMOID_ENTRIES; i++)
            t[i*16 +: 16] = sigmoid_entry(i, SIGMOID_ENTRIES);
        return t;
    endfunction

    localparam logic [SIGMOID_ENTRIES*16-1:0] SIG_ROM = build_sigmoid();

    logic       en;
    logic [3:0] done_reg;
    logic [3:0] rem;
    logic [1:0] sel;
    logic [3:0] sel_hot;
    logic       sel_last;
    logic       issue;
    logic [7:0] dr, dc;

    // stage a
    logic        a_valid_reg;
    logic [5:0]  a_plane_reg;
    logic [7:0]  a_row_reg, a_col_reg;
    logic [15:0] a_score_reg, a_offy_reg, a_offx_reg;
    logic        a_last_reg;
    logic [19:0] a_py_reg, a_px_reg;
    logic [11:0] a_sidx_reg;
    // stage b
    logic        b_valid_reg;
    logic [5:0]  b_plane_reg;
    logic [7:0]  b_row_reg, b_col_reg;
    logic [15:0] b_score_reg;
    logic        b_last_reg;
    logic [18:0] b_posy_reg, b_posx_reg;
    logic [IW-1:0] b_idx_reg;
    // output register
    logic        o_valid_reg;
    logic [5:0]  o_plane_reg;
    logic [7:0]  o_row_reg, o_col_reg;
    logic [15:0] o_score_reg, o_conf_reg;
    logic        o_last_reg;
    logic [18:0] o_posy_reg, o_posx_reg;

    logic signed [15:0] s_sel;
    logic signed [15:0] s_clamp;
    logic signed [25:0] sum_y, sum_x;
    logic [24:0]        idx_prod;

    assign en = !o_valid_reg || peak_ready;

    always_comb
    begin
        rem = head.peak & ~done_reg;
        sel = 2'd0;
        if (rem[0])
            sel = 2'd0;
        else if (rem[1])
            sel = 2'd1;
        else if (rem[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_hot = 4'd1 << sel;
        sel_last = ((rem & ~sel_hot) == 4'd0);
        dr = sel[1] ? head.row : head.row - 8'd1;
        dc = sel[0] ? head.col : head.col - 8'd1;
        s_sel = head.score[sel];
        if (s_sel < -16'sd2048)
            s_clamp = -16'sd2048;
        else if (s_sel > 16'sd2047)
            s_clamp = 16'sd2047;
        else
            s_clamp = s_sel;
    end

    assign issue = en && not_empty;
    assign pop = issue && sel_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 4'd0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= not_empty;
            b_valid_reg <= a_valid_reg;
            o_valid_reg <= b_valid_reg;
            if (issue)
                done_reg <= sel_last ? 4'd0 : (done_reg | sel_hot);
        end
    end

    assign sum_y = $signed({2'b0, a_py_reg, 4'b0}) + 26'(signed'(a_offy_reg));
    assign sum_x = $signed({2'b0, a_px_reg, 4'b0}) + 26'(signed'(a_offx_reg));
    assign idx_prod = {13'd0, a_sidx_reg} * {12'd0, N13};

    function automatic logic [18:0] sat19(input logic signed [25:0] v);
        if (v < -26'sd262144)
            return 19'h40000;
        else if (v > 26'sd262143)
            return 19'h3FFFF;
        else
            return v[18:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_plane_reg <= head.plane;
            a_row_reg <= dr;
            a_col_reg <= dc;
            a_score_reg <= s_sel;
            a_offy_reg <= head.off_y[sel];
            a_offx_reg <= head.off_x[sel];
            a_last_reg <= sel_last;
            a_py_reg <= dr * cfg.bh;
            a_px_reg <= dc * cfg.bw;
            a_sidx_reg <= 12'(s_clamp + 16'sd2048);

            b_plane_reg <= a_plane_reg;
            b_row_reg <= a_row_reg;
            b_col_reg <= a_col_reg;
            b_score_reg <= a_score_reg;
            b_last_reg <= a_last_reg;
            b_posy_reg <= sat19(sum_y);
            b_posx_reg <= sat19(sum_x);
            b_idx_reg <= idx_prod[12 +: IW];

            o_plane_reg <= b_plane_reg;
            o_row_reg <= b_row_reg;
            o_col_reg <= b_col_reg;
            o_score_reg <= b_score_reg;
            o_last_reg <= b_last_reg;
            o_posy_reg <= b_posy_reg;
            o_posx_reg <= b_posx_reg;
            o_conf_reg <= SIG_ROM[b_idx_reg*16 +: 16];
        end
    end

    assign peak_valid = o_valid_reg;
    assign keypoint_id = o_plane_reg;
    assign peak_row = o_row_reg;
    assign peak_column = o_col_reg;
    assign pos_y = o_posy_reg;
    assign pos_x = o_posx_reg;
    assign peak_logit = o_score_reg;
    assign confidence = o_conf_reg;
    assign last_of_run = o_last_reg;

endmodule

/* rtl/heatmap_peak_extract_top.sv */
// Top level of the heatmap peak extractor: APB registers, front end, queue, back end.
// Depends on hpe_pkg, hpe_front, hpe_queue and hpe_back.
//
//   channel   handshake                 payload
//   cell      cell_valid / cell_ready   cell_score, offset_y, offset_x
//   peak      peak_valid / peak_ready   keypoint_id .. last_of_run
//   apb       psel, penable, pready     paddr, pwdata, prdata
//
// One cell word per cycle while cell_ready is high, classified via registers s1 and s2;
// results pass stages a, b and the output register from the queue head, one per cycle
// while peak_ready allows, each job holding its queue slot until its last peak issues.
// cell_ready drops when the eight-entry queue cannot cover the words in flight.
// Reset clears counters and control; line buffer contents are not cleared.
module heatmap_peak_extract_top #(
    parameter int unsigned MAX_COLUMNS     = hpe_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_KEYPOINTS   = hpe_pkg::MAX_KEYPOINTS_DEF,
    parameter int unsigned SIGMOID_ENTRIES = hpe_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               cell_valid,
    output logic               cell_ready,
    input  logic signed [15:0] cell_score,
    input  logic signed [15:0] offset_y,
    input  logic signed [15:0] offset_x,
    output logic               peak_valid,
    input  logic               peak_ready,
    output logic [5:0]         keypoint_id,
    output logic [7:0]         peak_row,
    output logic [7:0]         peak_column,
    output logic signed [18:0] pos_y,
    output logic signed [18:0] pos_x,
    output logic signed [15:0] peak_logit,
    output logic [15:0]        confidence,
    output logic               last_of_run
);
    import hpe_pkg::*;

    localparam int unsigned COL_CAP = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0] thr_reg;
    logic [8:0]  rows_reg, cols_reg;
    logic [6:0]  kp_reg;
    logic [11:0] bw_reg, bh_reg;
    reg_idx_t    idx;
    logic        wr;
    cfg_t        cfg;

    logic          push, pop, not_empty;
    job_t          push_job, head;
    logic [QW-1:0] q_free;

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[4:2]);
    assign wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            rows_reg <= ROWS_RST;
            cols_reg <= COLUMNS_RST;
            kp_reg <= KEYPOINTS_RST;
            bw_reg <= BLOCK_W_RST;
            bh_reg <= BLOCK_H_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_THRESHOLD: thr_reg <= pwdata[15:0];
                REG_ROWS:      rows_reg <= pwdata[8:0];
                REG_COLUMNS:   cols_reg <= pwdata[8:0];
                REG_KEYPOINTS: kp_reg <= pwdata[6:0];
                REG_BLOCK_W:   bw_reg <= pwdata[11:0];
                REG_BLOCK_H:   bh_reg <= pwdata[11:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD: prdata = {16'd0, thr_reg};
            REG_ROWS:      prdata = {23'd0, rows_reg};
            REG_COLUMNS:   prdata = {23'd0, cols_reg};
            REG_KEYPOINTS: prdata = {25'd0, kp_reg};
            REG_BLOCK_W:   prdata = {20'd0, bw_reg};
            REG_BLOCK_H:   prdata = {20'd0, bh_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.thr = thr_reg;
        if (rows_reg < 9'd2)
            cfg.rows = 9'd2;
        else if (rows_reg > 9'd256)
            cfg.rows = 9'd256;
        else
            cfg.rows = rows_reg;
        if (cols_reg < 9'd2)
            cfg.cols = 9'd2;
        else if (cols_reg > 9'(COL_CAP))
            cfg.cols = 9'(COL_CAP);
        else
            cfg.cols = cols_reg;
        if (kp_reg < 7'd1)
            cfg.planes = 7'd1;
        else if (kp_reg > 7'(MAX_KEYPOINTS))
            cfg.planes = 7'(MAX_KEYPOINTS);
        else
            cfg.planes = kp_reg;
        cfg.bw = bw_reg;
        cfg.bh = bh_reg;
    end

    hpe_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_score (cell_score),
        .offset_y   (offset_y),
        .offset_x   (offset_x),
        .q_free     (q_free),
        .push       (push),
        .push_job   (push_job)
    );

    hpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .free      (q_free)
    );

    hpe_back #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .peak_valid  (peak_valid),
        .peak_ready  (peak_ready),
        .keypoint_id (keypoint_id),
        .peak_row    (peak_row),
        .peak_column (peak_column),
        .pos_y       (pos_y),
        .pos_x       (pos_x),
        .peak_logit  (peak_logit),
        .confidence  (confidence),
        .last_of_run (last_of_run)
    );

endmodule

/* test/tb_heatmap_peak_extract_top.sv */
// Testbench for heatmap_peak_extract_top: directed cell table, then random planes under
// several grid settings, every peak word checked against an in-bench 3x3 peak predictor.
// Depends on hpe_pkg and the RTL of heatmap_peak_extract_top.
module tb_heatmap_peak_extract_top;
    import hpe_pkg::*;

    typedef struct packed {
        logic [5:0]         kid;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [18:0] py;
        logic signed [18:0] px;
        logic signed [15:0] logit;
        logic [15:0]        conf;
        logic               last;
    } peak_t;

    typedef struct {
        logic signed [15:0] score;
        logic signed [15:0] oy;
        logic signed [15:0] ox;
        int                 n_peaks;   // -1: predictor only
    } cell_row_t;

    typedef struct {
        int thr;
        int rows;
        int cols;
        int kp;
        int bw;
        int bh;
        int planes;
    } grid_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic cell_valid = 1'b0;
    logic cell_ready;
    logic signed [15:0] cell_score = '0;
    logic signed [15:0] offset_y = '0;
    logic signed [15:0] offset_x = '0;
    logic peak_valid;
    logic peak_ready = 1'b0;
    logic [5:0] keypoint_id;
    logic [7:0] peak_row;
    logic [7:0] peak_column;
    logic signed [18:0] pos_y;
    logic signed [18:0] pos_x;
    logic signed [15:0] peak_logit;
    logic [15:0] confidence;
    logic last_of_run;

    heatmap_peak_extract_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cell_valid(cell_valid), .cell_ready(cell_ready),
        .cell_score(cell_score), .offset_y(offset_y), .offset_x(offset_x),
        .peak_valid(peak_valid), .peak_ready(peak_ready),
        .keypoint_id(keypoint_id), .peak_row(peak_row), .peak_column(peak_column),
        .pos_y(pos_y), .pos_x(pos_x), .peak_logit(peak_logit),
        .confidence(confidence), .last_of_run(last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [15:0]        conf_lut [1024];
    logic signed [15:0] thr_q = 16'sd217;
    logic [8:0]         rows_q = 9'd17;
    logic [8:0]         cols_q = 9'd17;
    logic [6:0]         kp_q = 7'd17;
    logic [11:0]        bw_q = 12'd16;
    logic [11:0]        bh_q = 12'd16;
    logic signed [15:0] line_score [3][256];
    logic [15:0]        line_oy [3][256];
    logic [15:0]        line_ox [3][256];
    int                 row_pos = 0;
    int                 col_pos = 0;
    int                 plane_pos = 0;

    peak_t expected_peaks[$];
    peak_t new_peaks[$];
    int    mismatches = 0;
    int    stall_cycles = 0;
    bit    quiet = 1'b0;
    bit    hold_req = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_left = 0;

    function automatic logic [15:0] sigmoid_point(int i);
        longint          d;
        longint unsigned mag;
        longint unsigned step;
        longint unsigned tk;
        longint          acc;
        longint unsigned ex;
        longint unsigned top;
        longint unsigned bottom;
        longint unsigned ratio;
        d = 2 * i + 1 - 1024;
        mag = (d < 0) ? -d : d;
        step = (mag << 30) / 1024;
        tk = 64'd1 << 31;
        acc = 64'sd1 << 31;
        for (int k = 1; k <= 14; k++)
        begin
            tk = ((tk * step) >> 31) / k;
            acc = (k % 2 == 1) ? acc - tk : acc + tk;
        end
        ex = (acc < 0) ? 0 : acc;
        if (ex > (64'd1 << 31))
            ex = 64'd1 << 31;
        repeat (4)
            ex = (ex * ex + (64'd1 << 30)) >> 31;
        top = (d >= 0) ? (64'd1 << 31) : ex;
        bottom = (64'd1 << 31) + ex;
        ratio = (top * 65536 + bottom / 2) / bottom;
        return (ratio > 65535) ? 16'hFFFF : ratio[15:0];
    endfunction

    function automatic logic signed [18:0] clip19(longint v);
        if (v < -262144)
            return -19'sd262144;
        if (v > 262143)
            return 19'sd262143;
        return v[18:0];
    endfunction

    task automatic judge_cell(int dr, int dc, int rows, int cols);
        logic signed [15:0] centre;
        logic signed [15:0] best;
        peak_t p;
        int s;
        centre = line_score[dr % 3][dc];
        best = centre;
        for (int y = (dr > 0 ? dr - 1 : 0); y <= (dr + 1 < rows ? dr + 1 : rows - 1); y++)
            for (int x = (dc > 0 ? dc - 1 : 0); x <= (dc + 1 < cols ? dc + 1 : cols - 1); x++)
                if (line_score[y % 3][x] > best)
                    best = line_score[y % 3][x];
        if (centre < thr_q || centre < best)
            return;
        s = (centre < -2048) ? -2048 : (centre > 2047 ? 2047 : int'(centre));
        p.kid = plane_pos[5:0];
        p.row = dr[7:0];
        p.col = dc[7:0];
        p.py = clip19(longint'(dr) * bh_q * 16 + longint'($signed(line_oy[dr % 3][dc])));
        p.px = clip19(longint'(dc) * bw_q * 16 + longint'($signed(line_ox[dr % 3][dc])));
        p.logit = centre;
        p.conf = conf_lut[(s + 2048) >> 2];
        p.last = 1'b0;
        new_peaks = {new_peaks, p};
    endtask

    // take one cell into the predictor, queue the peaks it completes
    task automatic take_cell(logic signed [15:0] sc, logic [15:0] oy, logic [15:0] ox,
                             output int n);
        int rows;
        int cols;
        int planes;
        int r;
        int c;
        rows = (rows_q < 2) ? 2 : (rows_q > 256 ? 256 : rows_q);
        cols = (cols_q < 2) ? 2 : (cols_q > 256 ? 256 : cols_q);
        planes = (kp_q < 1) ? 1 : (kp_q > 64 ? 64 : kp_q);
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rows) row_pos = 0;
        if (plane_pos >= planes) plane_pos = 0;
        r = row_pos;
        c = col_pos;
        line_score[r % 3][c] = sc;
        line_oy[r % 3][c] = oy;
        line_ox[r % 3][c] = ox;
        new_peaks.delete();
        if (r > 0 && c > 0) judge_cell(r - 1, c - 1, rows, cols);
        if (r > 0 && c == cols - 1) judge_cell(r - 1, c, rows, cols);
        if (r == rows - 1 && c > 0) judge_cell(r, c - 1, rows, cols);
        if (r == rows - 1 && c == cols - 1) judge_cell(r, c, rows, cols);
        n = new_peaks.size();
        if (n > 0)
            new_peaks[n - 1].last = 1'b1;
        foreach (new_peaks[i])
            expected_peaks = {expected_peaks, new_peaks[i]};
        col_pos = c + 1;
        if (col_pos >= cols)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= rows)
            begin
                row_pos = 0;
                plane_pos++;
                if (plane_pos >= planes) plane_pos = 0;
            end
        end
    endtask

    task automatic write_reg(reg_idx_t idx, int v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_q = v[15:0];
            REG_ROWS:      rows_q = v[8:0];
            REG_COLUMNS:   cols_q = v[8:0];
            REG_KEYPOINTS: kp_q = v[6:0];
            REG_BLOCK_W:   bw_q = v[11:0];
            REG_BLOCK_H:   bh_q = v[11:0];
            default: ;
        endcase
    endtask

    // offer one word, hold it until taken, then predict
    task automatic send_cell(logic signed [15:0] sc, logic [15:0] oy, logic [15:0] ox,
                             output int n);
        cell_valid <= 1'b1;
        cell_score <= sc;
        offset_y <= oy;
        offset_x <= ox;
        do
            @(negedge clk);
        while (!cell_ready);
        @(posedge clk);
        take_cell(sc, oy, ox, n);
        if (!quiet && $urandom_range(99) < 6)
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
    endtask

    // drop valid at the edge that took the last word, then wait until every expected peak has left
    task automatic drain;
        cell_valid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            peak_ready <= 1'b0;
        end
        else
            peak_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // check at the falling edge: the word is taken at the next rising edge
    always @(negedge clk)
    begin
        peak_t got;
        peak_t want;
        if (rst_n && peak_valid && peak_ready)
        begin
            got = '{keypoint_id, peak_row, peak_column, pos_y, pos_x, peak_logit,
                    confidence, last_of_run};
            if (expected_peaks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected peak word %p", got);
            end
            else
            begin
                want = expected_peaks.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("peak mismatch: expected %p got %p", want, got);
                end
            end
        end
        if ((cell_valid && cell_ready) || (peak_valid && peak_ready))
            stall_cycles = 0;
        else if (++stall_cycles >= 3000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    cell_row_t cell_table[] = '{
        // all at maximum: every cell of the 2x2 plane is a peak, all on the last cell
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4},
        // all at minimum: below threshold, nothing
        '{-16'sh8000, -16'sh8000, -16'sh8000, 0}, '{-16'sh8000, -16'sh8000, -16'sh8000, 0},
        '{-16'sh8000, -16'sh8000, -16'sh8000, 0}, '{-16'sh8000, -16'sh8000, -16'sh8000, 0},
        // single corner peak, decided on the last cell
        '{16'sd1000, 16'sh8000, 16'sh7FFF, 0}, '{16'sd0, 16'sd5, 16'sd6, 0},
        '{16'sd0, 16'sd7, 16'sd8, 0}, '{16'sd0, 16'sd9, 16'sd10, 1},
        // ties at threshold: all peaks
        '{16'sd217, -16'sd1, -16'sd1, 0}, '{16'sd217, 16'sd1, 16'sd1, 0},
        '{16'sd217, 16'sd2, 16'sd2, 0}, '{16'sd217, 16'sd3, 16'sd3, 4},
        // one below threshold, others at or beyond the sigmoid clamp
        '{16'sd216, 16'sh5555, 16'shAAAA, 0}, '{16'sd3000, 16'shAAAA, 16'sh5555, -1},
        '{16'sd2047, 16'sh1234, 16'sh4321, -1}, '{16'sd2048, 16'sh0F0F, 16'shF0F0, -1}
    };

    grid_set_t grid_sets[] = '{
        '{217, 4, 5, 3, 16, 16, 3},
        '{-32768, 3, 3, 1, 4095, 4095, 4},
        '{32767, 2, 2, 2, 0, 0, 4},
        '{0, 0, 40, 127, 4095, 4095, 1},
        '{100, 30, 2, 1, 4095, 4095, 1},
        '{-100, 6, 7, 5, 123, 45, 2},
        '{50, 3, 4, 2, 7, 9, 2}
    };

    initial
    begin
        int n;
        int cells;
        bit wide;
        logic signed [15:0] sc;
        for (int i = 0; i < 1024; i++)
            conf_lut[i] = sigmoid_point(i);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_ROWS, 2);
        write_reg(REG_COLUMNS, 2);
        write_reg(REG_KEYPOINTS, 64);
        foreach (cell_table[i])
        begin
            send_cell(cell_table[i].score, cell_table[i].oy, cell_table[i].ox, n);
            if (cell_table[i].n_peaks >= 0 && n != cell_table[i].n_peaks)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cell %0d: expected %0d peaks, predicted %0d",
                             i, cell_table[i].n_peaks, n);
            end
        end
        drain();
        foreach (grid_sets[g])
        begin
            // plane boundary: keep line reads inside written rows
            while (row_pos != 0 || col_pos != 0)
                send_cell(16'($urandom), 16'($urandom), 16'($urandom), n);
            drain();
            write_reg(REG_THRESHOLD, grid_sets[g].thr);
            write_reg(REG_ROWS, grid_sets[g].rows);
            write_reg(REG_COLUMNS, grid_sets[g].cols);
            write_reg(REG_KEYPOINTS, grid_sets[g].kp);
            write_reg(REG_BLOCK_W, grid_sets[g].bw);
            write_reg(REG_BLOCK_H, grid_sets[g].bh);
            quiet = (g == 3);
            if (g == 5)
                hold_req = 1'b1;
            cells = grid_sets[g].planes
                  * ((rows_q < 2) ? 2 : (rows_q > 256 ? 256 : rows_q))
                  * ((cols_q < 2) ? 2 : (cols_q > 256 ? 256 : cols_q));
            for (int k = 0; k < cells; k++)
            begin
                if (g == 0 && k == cells / 2)
                begin
                    // pause until every peak has left
                    cell_valid <= 1'b0;
                    while (expected_peaks.size() != 0)
                        @(posedge clk);
                end
                wide = ($urandom_range(99) < 20);
                sc = wide ? 16'($urandom) : 16'($urandom_range(600)) - 16'sd300;
                send_cell(sc, 16'($urandom), 16'($urandom), n);
            end
            quiet = 1'b0;
        end
        drain();
        if (mismatches == 0 && expected_peaks.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
